### hw/rtl/numeric_literal_suffix_lexer_assert.svh
// assertion macros for the numeric literal suffix lexer
`ifndef NUMERIC_LITERAL_SUFFIX_LEXER_ASSERT_SVH
`define NUMERIC_LITERAL_SUFFIX_LEXER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NLSL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define NLSL_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/nlsl_pkg.sv
// package with types, codes and the final suffix check of the suffix lexer
package nlsl_pkg;

    localparam logic [7:0] CH_LOW_U   = 8'h75;
    localparam logic [7:0] CH_LOW_L   = 8'h6c;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_LOW_D   = 8'h64;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7a;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5a;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    localparam logic [1:0] LEN_MAX = 2'd3;

    localparam logic [3:0] ERR_NONE            = 4'd0;
    localparam logic [3:0] ERR_DUP_U           = 4'd1;
    localparam logic [3:0] ERR_DUP_L           = 4'd2;
    localparam logic [3:0] ERR_DUP_FLOAT       = 4'd3;
    localparam logic [3:0] ERR_DUP_L_AFTER_U   = 4'd4;
    localparam logic [3:0] ERR_BAD_AFTER_U     = 4'd5;
    localparam logic [3:0] ERR_DUP_LL          = 4'd6;
    localparam logic [3:0] ERR_BAD_AFTER_L     = 4'd7;
    localparam logic [3:0] ERR_BAD_AFTER_LL    = 4'd8;
    localparam logic [3:0] ERR_BAD_AFTER_F     = 4'd9;
    localparam logic [3:0] ERR_BAD_AFTER_D     = 4'd10;
    localparam logic [3:0] ERR_FLOAT_WITH_INT  = 4'd11;
    localparam logic [3:0] ERR_F_WITH_D        = 4'd12;
    localparam logic [3:0] ERR_L_WITH_LL       = 4'd13;
    localparam logic [3:0] ERR_INT_ON_FLOAT    = 4'd14;
    localparam logic [3:0] ERR_FLOAT_ON_INT    = 4'd15;

    typedef enum logic [2:0] {
        ST_START,
        ST_AFTER_U,
        ST_AFTER_L,
        ST_AFTER_LL,
        ST_AFTER_F,
        ST_AFTER_D
    } scan_state_t;

    typedef enum logic [1:0] {
        ACT_TAKE,
        ACT_FAIL,
        ACT_STOP
    } scan_act_t;

    typedef struct packed {
        logic d;
        logic f;
        logic ll;
        logic l;
        logic u;
    } suffix_flags_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       literal_is_float;
        logic       at_end;
    } nlsl_item_t;

    typedef struct packed {
        logic          failed;
        logic [3:0]    error_code;
        logic [1:0]    suffix_length;
        suffix_flags_t flags;
    } nlsl_result_t;

    typedef struct packed {
        logic emit;
        logic live;
    } nlsl_scan_status_t;

    function automatic logic [3:0] final_check(input suffix_flags_t fl, input logic kind_float);
        logic fl_any;
        logic in_any;
        logic [3:0] code;
        fl_any = fl.f | fl.d;
        in_any = fl.u | fl.l | fl.ll;
        code = ERR_NONE;
        if (fl_any && in_any)
        begin
            code = ERR_FLOAT_WITH_INT;
        end
        else if (fl.f && fl.d)
        begin
            code = ERR_F_WITH_D;
        end
        else if (fl.l && fl.ll)
        begin
            code = ERR_L_WITH_LL;
        end
        else if (kind_float && in_any)
        begin
            code = ERR_INT_ON_FLOAT;
        end
        else if (!kind_float && fl_any)
        begin
            code = ERR_FLOAT_ON_INT;
        end
        return code;
    endfunction

endpackage

### hw/rtl/nlsl_in_stage.sv
// input register stage of the suffix lexer
module nlsl_in_stage
    import nlsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  nlsl_item_t in_item,
    input  logic       advance,
    output logic       s1_valid,
    output nlsl_item_t s1_item
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    nlsl_item_t s1_item_reg;
    logic       load;

    assign in_ready = !s1_valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_item_reg <= in_item;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

endmodule

### hw/rtl/nlsl_scan.sv
// suffix scanner state and the per-character decision logic
module nlsl_scan
    import nlsl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  nlsl_item_t        item,
    input  logic              fire,
    output nlsl_scan_status_t status,
    output nlsl_result_t      result
);

    scan_state_t   state_reg;
    scan_state_t   state_next;
    suffix_flags_t flags_reg;
    suffix_flags_t flags_next;
    logic          kind_reg;
    logic          kind_next;
    logic [1:0]    cons_reg;
    logic [1:0]    cons_next;
    logic          finished_reg;
    logic          finished_next;

    scan_state_t   st;
    suffix_flags_t fl;
    suffix_flags_t fl_take;
    logic [1:0]    cn;
    logic          kf;
    logic          live;
    logic [7:0]    lc;
    logic          is_letter;
    logic          is_u;
    logic          is_l;
    logic          is_f;
    logic          is_d;
    scan_act_t     act;
    scan_state_t   st_take;
    logic [3:0]    fail_code;
    logic [3:0]    stop_code;
    logic          emit;

    // effective state after a first item clears it, with the long flag repair
    always_comb
    begin
        st   = item.first ? ST_START : state_reg;
        cn   = item.first ? 2'd0 : cons_reg;
        kf   = item.first ? item.literal_is_float : kind_reg;
        live = item.first || !finished_reg;
        fl   = item.first ? suffix_flags_t'('0) : flags_reg;
        lc   = ((item.ch >= CH_UP_A) && (item.ch <= CH_UP_Z)) ? item.ch + CASE_SHIFT : item.ch;
        is_letter = (lc >= CH_LOW_A) && (lc <= CH_LOW_Z);
        is_u = (lc == CH_LOW_U);
        is_l = (lc == CH_LOW_L);
        is_f = (lc == CH_LOW_F);
        is_d = (lc == CH_LOW_D);
        if ((st == ST_AFTER_L) && (item.at_end || !is_l))
        begin
            fl.l = 1'b1;
        end
    end

    // next state decision
    always_comb
    begin
        act       = ACT_STOP;
        st_take   = st;
        fl_take   = fl;
        fail_code = ERR_NONE;
        if (!item.at_end)
        begin
            unique case (st)
                ST_START:
                begin
                    if (is_u)
                    begin
                        if (fl.u)
                        begin
                            act = ACT_FAIL;
                            fail_code = ERR_DUP_U;
                        end
                        else
                        begin
                            act = ACT_TAKE;
                            st_take = ST_AFTER_U;
                            fl_take.u = 1'b1;
                        end
                    end
                    else if (is_l)
                    begin
                        if (fl.l || fl.ll)
                        begin
                            act = ACT_FAIL;
                            fail_code = ERR_DUP_L;
                        end
                        else
                        begin
                            act = ACT_TAKE;
                            st_take = ST_AFTER_L;
                        end
                    end
                    else if (is_f || is_d)
                    begin
                        if (fl.f || fl.d)
                        begin
                            act = ACT_FAIL;
                            fail_code = ERR_DUP_FLOAT;
                        end
                        else
                        begin
                            act = ACT_TAKE;
                            st_take = is_f ? ST_AFTER_F : ST_AFTER_D;
                            fl_take.f = fl.f | is_f;
                            fl_take.d = fl.d | is_d;
                        end
                    end
                end
                ST_AFTER_U:
                begin
                    if (is_l)
                    begin
                        if (fl.l || fl.ll)
                        begin
                            act = ACT_FAIL;
                            fail_code = ERR_DUP_L_AFTER_U;
                        end
                        else
                        begin
                            act = ACT_TAKE;
                            st_take = ST_AFTER_L;
                        end
                    end
                    else if (is_letter)
                    begin
                        act = ACT_FAIL;
                        fail_code = ERR_BAD_AFTER_U;
                    end
                end
                ST_AFTER_L:
                begin
                    if (is_l)
                    begin
                        if (fl.ll)
                        begin
                            act = ACT_FAIL;
                            fail_code = ERR_DUP_LL;
                        end
                        else
                        begin
                            act = ACT_TAKE;
                            st_take = ST_AFTER_LL;
                            fl_take.ll = 1'b1;
                            fl_take.l = 1'b0;
                        end
                    end
                    else if (is_u)
                    begin
                        if (fl.u)
                        begin
                            act = ACT_FAIL;
                            fail_code = ERR_DUP_U;
                        end
                        else
                        begin
                            act = ACT_TAKE;
                            st_take = ST_AFTER_U;
                            fl_take.u = 1'b1;
                        end
                    end
                    else if (is_letter)
                    begin
                        act = ACT_FAIL;
                        fail_code = ERR_BAD_AFTER_L;
                    end
                end
                ST_AFTER_LL:
                begin
                    if (is_u)
                    begin
                        if (fl.u)
                        begin
                            act = ACT_FAIL;
                            fail_code = ERR_DUP_U;
                        end
                        else
                        begin
                            act = ACT_TAKE;
                            st_take = ST_AFTER_U;
                            fl_take.u = 1'b1;
                        end
                    end
                    else if (is_letter)
                    begin
                        act = ACT_FAIL;
                        fail_code = ERR_BAD_AFTER_LL;
                    end
                end
                ST_AFTER_F:
                begin
                    if (is_letter)
                    begin
                        act = ACT_FAIL;
                        fail_code = ERR_BAD_AFTER_F;
                    end
                end
                ST_AFTER_D:
                begin
                    if (is_letter)
                    begin
                        act = ACT_FAIL;
                        fail_code = ERR_BAD_AFTER_D;
                    end
                end
                default:
                begin
                    act = ACT_STOP;
                end
            endcase
        end
    end

    // result and register updates
    always_comb
    begin
        emit      = live && (act != ACT_TAKE);
        stop_code = final_check(fl, kf);
        result.flags = fl;
        case (act)
            ACT_FAIL:
            begin
                result.error_code    = fail_code;
                result.suffix_length = cn;
            end
            ACT_STOP:
            begin
                result.error_code    = stop_code;
                result.suffix_length = (stop_code != ERR_NONE) ? 2'd0 : cn;
            end
            default:
            begin
                result.error_code    = ERR_NONE;
                result.suffix_length = cn;
            end
        endcase
        result.failed = (result.error_code != ERR_NONE);

        state_next    = state_reg;
        flags_next    = flags_reg;
        kind_next     = kind_reg;
        cons_next     = cons_reg;
        finished_next = finished_reg;
        if (fire && live)
        begin
            kind_next     = kf;
            finished_next = emit;
            if (act == ACT_TAKE)
            begin
                state_next = st_take;
                flags_next = fl_take;
                cons_next  = (cn == LEN_MAX) ? LEN_MAX : cn + 2'd1;
            end
            else
            begin
                state_next = st;
                flags_next = fl;
                cons_next  = cn;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_START;
            flags_reg    <= '0;
            kind_reg     <= 1'b0;
            cons_reg     <= 2'd0;
            finished_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            flags_reg    <= flags_next;
            kind_reg     <= kind_next;
            cons_reg     <= cons_next;
            finished_reg <= finished_next;
        end
    end

    assign status.emit = emit;
    assign status.live = live;

endmodule

### hw/rtl/nlsl_out_stage.sv
// result register stage of the suffix lexer
module nlsl_out_stage
    import nlsl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  nlsl_result_t load_result,
    output logic         out_free,
    output logic         out_valid,
    input  logic         out_ready,
    output nlsl_result_t out_result
);

    logic         out_valid_reg;
    logic         out_valid_next;
    nlsl_result_t out_result_reg;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_result_reg <= load_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

### hw/rtl/numeric_literal_suffix_lexer.sv
// top level of the numeric literal suffix lexer
// input channel: one character transaction per cycle (ch, first, literal_is_float,
// at_end) on in_valid / in_ready; first opens a new suffix and latches the kind
// output channel: one result transaction per finished suffix on out_valid / out_ready,
// carrying failed, error_code, suffix_length and the five suffix flags
// a character that is taken as part of the suffix gives no result transaction
// the transaction that ends the suffix is held in the input register, scanned, and its
// result is held in the result register, which drives out_valid / out_ready
// throughput: one input transaction per cycle while in_ready is high, set by the
// combinational scanner between the input register and the result register
// when the receiver stalls, characters that give no result keep flowing; the
// transaction that ends a suffix waits in the input register until the result
// register frees, and in_ready is low while it waits
// reset: both registers empty, scanner at start and waiting for a first transaction;
// transactions without first are dropped until one arrives
`include "numeric_literal_suffix_lexer_assert.svh"

module numeric_literal_suffix_lexer
    import nlsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       first,
    input  logic       literal_is_float,
    input  logic       at_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       failed,
    output logic [3:0] error_code,
    output logic [1:0] suffix_length,
    output logic       is_unsigned,
    output logic       is_long,
    output logic       is_long_long,
    output logic       is_single_float,
    output logic       is_double_float
);

    nlsl_item_t        in_item;
    nlsl_item_t        s1_item;
    logic              s1_valid;
    logic              advance;
    logic              out_free;
    nlsl_scan_status_t status;
    nlsl_result_t      scan_result;
    nlsl_result_t      out_result;

    assign in_item.ch               = ch;
    assign in_item.first            = first;
    assign in_item.literal_is_float = literal_is_float;
    assign in_item.at_end           = at_end;

    assign advance = s1_valid && (!status.emit || out_free);

    nlsl_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    nlsl_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (s1_item),
        .fire   (advance),
        .status (status),
        .result (scan_result)
    );

    nlsl_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && status.emit),
        .load_result (scan_result),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_result  (out_result)
    );

    assign failed          = out_result.failed;
    assign error_code      = out_result.error_code;
    assign suffix_length   = out_result.suffix_length;
    assign is_unsigned     = out_result.flags.u;
    assign is_long         = out_result.flags.l;
    assign is_long_long    = out_result.flags.ll;
    assign is_single_float = out_result.flags.f;
    assign is_double_float = out_result.flags.d;

    `NLSL_ASSERT_IMP(a_failed_matches_code, out_valid,
        failed == (error_code != ERR_NONE), "failed flag disagrees with error code")
    `NLSL_ASSERT_IMP(a_final_fail_no_length, out_valid && (error_code >= ERR_FLOAT_WITH_INT),
        suffix_length == 2'd0, "final check failure with nonzero length")
    `NLSL_ASSERT_IMP(a_long_exclusive, out_valid,
        !(is_long && is_long_long), "long and long long both set")
    `NLSL_ASSERT_NXT(a_result_loads_valid, advance && status.emit,
        out_valid, "emitted result not presented")

endmodule

### tb/numeric_literal_suffix_lexer_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the numeric literal suffix lexer
module numeric_literal_suffix_lexer_tb;
    import nlsl_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] ch;
    logic       first;
    logic       literal_is_float;
    logic       at_end;
    logic       out_valid;
    logic       out_ready;
    logic       failed;
    logic [3:0] error_code;
    logic [1:0] suffix_length;
    logic       is_unsigned;
    logic       is_long;
    logic       is_long_long;
    logic       is_single_float;
    logic       is_double_float;

    typedef struct {
        logic [7:0]   ch;
        logic         first;
        logic         lit_float;
        logic         at_end;
        bit           typed;
        nlsl_result_t want;
    } stim_row_t;

    scan_state_t   lx_state;
    suffix_flags_t lx_flags;
    logic          lx_float;
    logic [1:0]    lx_len;
    logic          lx_idle;

    nlsl_result_t suffix_verdicts[$];
    stim_row_t    stim_rows[$];
    int           mismatches;
    bit           quiet;

    numeric_literal_suffix_lexer DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .ch               (ch),
        .first            (first),
        .literal_is_float (literal_is_float),
        .at_end           (at_end),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .failed           (failed),
        .error_code       (error_code),
        .suffix_length    (suffix_length),
        .is_unsigned      (is_unsigned),
        .is_long          (is_long),
        .is_long_long     (is_long_long),
        .is_single_float  (is_single_float),
        .is_double_float  (is_double_float)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic scan_act_t add_unsigned(output logic [3:0] code,
                                               output scan_state_t nxt);
        code = ERR_DUP_U;
        nxt = ST_AFTER_U;
        if (lx_flags.u)
        begin
            return ACT_FAIL;
        end
        lx_flags.u = 1'b1;
        return ACT_TAKE;
    endfunction

    function automatic bit lex_suffix_char(input logic [7:0] c_in, input logic is_first,
                                           input logic lit_float, input logic end_in,
                                           output nlsl_result_t res, output bit dropped);
        logic [7:0]  c;
        logic        letter;
        logic        flt;
        logic        intg;
        logic [3:0]  code;
        scan_state_t nxt;
        scan_act_t   act;
        res = '0;
        dropped = 1'b0;
        if (is_first)
        begin
            lx_state = ST_START;
            lx_flags = '0;
            lx_len = 2'd0;
            lx_float = lit_float;
            lx_idle = 1'b0;
        end
        else if (lx_idle)
        begin
            dropped = 1'b1;
            return 1'b0;
        end
        c = (c_in >= CH_UP_A && c_in <= CH_UP_Z) ? c_in + CASE_SHIFT : c_in;
        letter = c >= CH_LOW_A && c <= CH_LOW_Z;
        act = ACT_STOP;
        code = ERR_NONE;
        nxt = lx_state;
        if (end_in)
        begin
            if (lx_state == ST_AFTER_L)
            begin
                lx_flags.l = 1'b1;
            end
        end
        else
        begin
            // leaving after-l by anything but a second l makes it a plain long
            if (lx_state == ST_AFTER_L && c != CH_LOW_L)
            begin
                lx_flags.l = 1'b1;
            end
            case (lx_state)
                ST_START:
                begin
                    if (c == CH_LOW_U)
                    begin
                        act = add_unsigned(code, nxt);
                    end
                    else if (c == CH_LOW_L)
                    begin
                        act = (lx_flags.l || lx_flags.ll) ? ACT_FAIL : ACT_TAKE;
                        code = ERR_DUP_L;
                        nxt = ST_AFTER_L;
                    end
                    else if (c == CH_LOW_F || c == CH_LOW_D)
                    begin
                        code = ERR_DUP_FLOAT;
                        if (lx_flags.f || lx_flags.d)
                        begin
                            act = ACT_FAIL;
                        end
                        else
                        begin
                            act = ACT_TAKE;
                            lx_flags.f = c == CH_LOW_F;
                            lx_flags.d = c == CH_LOW_D;
                            nxt = (c == CH_LOW_F) ? ST_AFTER_F : ST_AFTER_D;
                        end
                    end
                end
                ST_AFTER_U:
                begin
                    if (c == CH_LOW_L)
                    begin
                        act = (lx_flags.l || lx_flags.ll) ? ACT_FAIL : ACT_TAKE;
                        code = ERR_DUP_L_AFTER_U;
                        nxt = ST_AFTER_L;
                    end
                    else
                    begin
                        act = letter ? ACT_FAIL : ACT_STOP;
                        code = ERR_BAD_AFTER_U;
                    end
                end
                ST_AFTER_L:
                begin
                    if (c == CH_LOW_L)
                    begin
                        code = ERR_DUP_LL;
                        if (lx_flags.ll)
                        begin
                            act = ACT_FAIL;
                        end
                        else
                        begin
                            act = ACT_TAKE;
                            lx_flags.ll = 1'b1;
                            lx_flags.l = 1'b0;
                            nxt = ST_AFTER_LL;
                        end
                    end
                    else if (c == CH_LOW_U)
                    begin
                        act = add_unsigned(code, nxt);
                    end
                    else
                    begin
                        act = letter ? ACT_FAIL : ACT_STOP;
                        code = ERR_BAD_AFTER_L;
                    end
                end
                ST_AFTER_LL:
                begin
                    if (c == CH_LOW_U)
                    begin
                        act = add_unsigned(code, nxt);
                    end
                    else
                    begin
                        act = letter ? ACT_FAIL : ACT_STOP;
                        code = ERR_BAD_AFTER_LL;
                    end
                end
                ST_AFTER_F:
                begin
                    act = letter ? ACT_FAIL : ACT_STOP;
                    code = ERR_BAD_AFTER_F;
                end
                ST_AFTER_D:
                begin
                    act = letter ? ACT_FAIL : ACT_STOP;
                    code = ERR_BAD_AFTER_D;
                end
                default:
                begin
                    act = ACT_STOP;
                end
            endcase
        end
        if (act == ACT_TAKE)
        begin
            lx_state = nxt;
            if (lx_len != LEN_MAX)
            begin
                lx_len = lx_len + 2'd1;
            end
            return 1'b0;
        end
        if (act == ACT_STOP)
        begin
            flt = lx_flags.f | lx_flags.d;
            intg = lx_flags.u | lx_flags.l | lx_flags.ll;
            code = ERR_NONE;
            if (flt && intg)
            begin
                code = ERR_FLOAT_WITH_INT;
            end
            else if (lx_flags.f && lx_flags.d)
            begin
                code = ERR_F_WITH_D;
            end
            else if (lx_flags.l && lx_flags.ll)
            begin
                code = ERR_L_WITH_LL;
            end
            else if (lx_float && intg)
            begin
                code = ERR_INT_ON_FLOAT;
            end
            else if (!lx_float && flt)
            begin
                code = ERR_FLOAT_ON_INT;
            end
        end
        res.failed = code != ERR_NONE;
        res.error_code = code;
        res.suffix_length = (act == ACT_STOP && code != ERR_NONE) ? 2'd0 : lx_len;
        res.flags = lx_flags;
        lx_idle = 1'b1;
        return 1'b1;
    endfunction

    function automatic void add_row(input logic [7:0] c, input logic f, input logic lf,
                                    input logic e, input bit typed = 1'b0,
                                    input nlsl_result_t w = '0);
        stim_row_t r;
        r.ch = c;
        r.first = f;
        r.lit_float = lf;
        r.at_end = e;
        r.typed = typed;
        r.want = w;
        stim_rows.push_back(r);
    endfunction

    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                case ($urandom_range(0, 3))
                    0: c = CH_LOW_U;
                    1: c = CH_LOW_L;
                    2: c = CH_LOW_F;
                    default: c = CH_LOW_D;
                endcase
                if ($urandom_range(0, 1) != 0)
                begin
                    c = c - CASE_SHIFT;
                end
            end
            6, 7:
            begin
                c = CH_LOW_A + 8'($urandom_range(0, 25));
                if ($urandom_range(0, 1) != 0)
                begin
                    c = c - CASE_SHIFT;
                end
            end
            default:
            begin
                c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic f, input logic lf,
                             input logic e, output bit got, output nlsl_result_t res,
                             output bit dropped);
        int gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        first <= f;
        literal_is_float <= lf;
        at_end <= e;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        got = lex_suffix_char(c, f, lf, e, res, dropped);
    endtask

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result();
        nlsl_result_t want;
        if (suffix_verdicts.size() == 0)
        begin
            $display("%0t: unexpected result, expected none actual code %0d", $time,
                     error_code);
            mismatches++;
        end
        else
        begin
            want = suffix_verdicts.pop_front();
            compare_field("failed", want.failed, failed);
            compare_field("error_code", want.error_code, error_code);
            compare_field("suffix_length", want.suffix_length, suffix_length);
            compare_field("is_unsigned", want.flags.u, is_unsigned);
            compare_field("is_long", want.flags.l, is_long);
            compare_field("is_long_long", want.flags.ll, is_long_long);
            compare_field("is_single_float", want.flags.f, is_single_float);
            compare_field("is_double_float", want.flags.d, is_double_float);
        end
    endtask

    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            check_result();
        end
    end

    initial
    begin
        int           accepted_items;
        int           run_len;
        bit           got;
        bit           dropped;
        bit           is_first;
        nlsl_result_t res;
        rst_n = 1'b0;
        in_valid = 1'b0;
        ch = 8'h00;
        first = 1'b0;
        literal_is_float = 1'b0;
        at_end = 1'b0;
        quiet = 1'b0;
        mismatches = 0;
        accepted_items = 0;
        lx_state = ST_START;
        lx_flags = '0;
        lx_float = 1'b0;
        lx_len = 2'd0;
        lx_idle = 1'b1;

        // flags order: d f ll l u
        add_row("u", 1'b0, 1'b0, 1'b0);
        add_row(8'hff, 1'b1, 1'b0, 1'b1, 1'b1, {1'b0, ERR_NONE, 2'd0, 5'b00000});
        add_row("u", 1'b1, 1'b0, 1'b0);
        add_row("L", 1'b0, 1'b0, 1'b0);
        add_row("l", 1'b0, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, 1'b1);
        add_row("l", 1'b1, 1'b0, 1'b0);
        add_row(8'h20, 1'b0, 1'b0, 1'b1);
        add_row("f", 1'b1, 1'b1, 1'b0);
        add_row("x", 1'b0, 1'b0, 1'b0, 1'b1, {1'b1, ERR_BAD_AFTER_F, 2'd1, 5'b01000});
        add_row("D", 1'b1, 1'b0, 1'b0);
        add_row(8'h80, 1'b0, 1'b0, 1'b0, 1'b1, {1'b1, ERR_FLOAT_ON_INT, 2'd0, 5'b10000});
        add_row("u", 1'b1, 1'b1, 1'b0);
        add_row(8'hff, 1'b0, 1'b0, 1'b0, 1'b1, {1'b1, ERR_INT_ON_FLOAT, 2'd0, 5'b00001});
        add_row("u", 1'b1, 1'b0, 1'b0);
        add_row("L", 1'b1, 1'b1, 1'b0);
        add_row("U", 1'b0, 1'b0, 1'b0);
        add_row("l", 1'b0, 1'b0, 1'b0);
        add_row("l", 1'b1, 1'b0, 1'b0);
        add_row("l", 1'b0, 1'b0, 1'b0);
        add_row("z", 1'b0, 1'b0, 1'b0);
        add_row("u", 1'b1, 1'b0, 1'b0);
        add_row("l", 1'b0, 1'b0, 1'b0);
        add_row("u", 1'b0, 1'b0, 1'b0);
        add_row("l", 1'b1, 1'b0, 1'b0);
        add_row("k", 1'b0, 1'b0, 1'b0);
        add_row("d", 1'b1, 1'b1, 1'b0);
        add_row("A", 1'b0, 1'b0, 1'b0, 1'b1, {1'b1, ERR_BAD_AFTER_D, 2'd1, 5'b10000});
        add_row("u", 1'b1, 1'b0, 1'b0);
        add_row("u", 1'b0, 1'b0, 1'b0);
        add_row("q", 1'b1, 1'b0, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            send_char(stim_rows[i].ch, stim_rows[i].first, stim_rows[i].lit_float,
                      stim_rows[i].at_end, got, res, dropped);
            if (got)
            begin
                suffix_verdicts.push_back(stim_rows[i].typed ? stim_rows[i].want : res);
            end
        end

        // hold off until the directed results have drained
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (suffix_verdicts.size() != 0);

        while (accepted_items < 2000)
        begin
            run_len = $urandom_range(1, 5);
            for (int k = 0; k < run_len; k++)
            begin
                is_first = (k == 0) ? ($urandom_range(0, 19) != 0)
                                    : ($urandom_range(0, 19) == 0);
                send_char(pick_char(), is_first, 1'($urandom_range(0, 1)),
                          $urandom_range(0, 5) == 0, got, res, dropped);
                if (got)
                begin
                    suffix_verdicts.push_back(res);
                end
                if (!dropped)
                begin
                    accepted_items++;
                    if (accepted_items % 150 == 0)
                    begin
                        quiet = $urandom_range(0, 2) == 0;
                    end
                    if (accepted_items == 1000)
                    begin
                        in_valid <= 1'b0;
                        do
                        begin
                            @(posedge clk);
                        end
                        while (suffix_verdicts.size() != 0);
                    end
                end
            end
        end

        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (suffix_verdicts.size() != 0);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
